FILE: hdl/tqvg_pkg.sv
`timescale 1ns / 1ps

package tqvg_pkg;

    // Texture coordinate format: unsigned, one integer bit
    localparam int TEX_FRAC_BITS = 16;
    localparam int TEX_W         = TEX_FRAC_BITS + 1;
    localparam int TEX_ONE       = 1 << TEX_FRAC_BITS;

    // Field and register widths
    localparam int TILE_W      = 16;
    localparam int QUO_W       = TILE_W - 1;
    localparam int POS_W       = 11;
    localparam int MAP_REG_W   = 11;
    localparam int ATLAS_REG_W = 9;
    localparam int STEP_W      = 17;
    localparam int PAD_W       = 16;
    localparam int CORNER_W    = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 17;
    localparam int PROD_W      = QUO_W + STEP_W;
    localparam int SUM_W       = PROD_W + 3;

    localparam logic [STEP_W-1:0]   STEP_RESET  = STEP_W'(65536);
    localparam logic [CORNER_W-1:0] LAST_CORNER = CORNER_W'(5);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_WIDTH     = 3'd0,
        CFG_MAP_HEIGHT    = 3'd1,
        CFG_ATLAS_COLUMNS = 3'd2,
        CFG_UV_STEP_X     = 3'd3,
        CFG_UV_STEP_Y     = 3'd4,
        CFG_PAD_X         = 3'd5,
        CFG_PAD_Y         = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL_U,
        ST_MUL_V,
        ST_SAT_V,
        ST_EMIT
    } state_t;

    // Clamp a signed sum into 0 .. one
    function automatic logic [TEX_W-1:0] sat_tex(input logic signed [SUM_W-1:0] v);
        logic [TEX_W-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > $signed(SUM_W'(TEX_ONE)))
            r = TEX_W'(TEX_ONE);
        else
            r = v[TEX_W-1:0];
        return r;
    endfunction

endpackage

FILE: hdl/tqvg_if.sv
`timescale 1ns / 1ps

interface tqvg_tile_if;
    import tqvg_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [TILE_W-1:0] tile_index;

    modport source (output valid, output tile_index, input ready);
    modport sink   (input valid, input tile_index, output ready);
endinterface

interface tqvg_vertex_if;
    import tqvg_pkg::*;

    logic                valid;
    logic                ready;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [TEX_W-1:0]    tex_u;
    logic [TEX_W-1:0]    tex_v;
    logic [CORNER_W-1:0] corner;
    logic                last_of_quad;

    modport source (output valid, output pos_x, output pos_y, output tex_u, output tex_v,
                    output corner, output last_of_quad, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input tex_u, input tex_v,
                    input corner, input last_of_quad, output ready);
endinterface

FILE: hdl/tqvg_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module tqvg_div #(
    parameter int DIVISOR_W = 9
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [tqvg_pkg::QUO_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0]           divisor,
    output logic                           done,
    output logic [tqvg_pkg::QUO_W-1:0]     quotient,
    output logic [DIVISOR_W-1:0]           remainder
);
    import tqvg_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUO_W - 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [QUO_W-1:0]     quo_reg;

    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = (trial >= {1'b0, divisor});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: hdl/tile_quad_vertex_generator_core.sv
// Channel    Dir  Payload                                         Transaction
// tiles      in   tile_index                                      valid & ready
// vertices   out  pos_x pos_y tex_u tex_v corner last_of_quad     valid & ready
// wr_*       in   wr_index wr_data                                wr_en
//
// Empty cell (negative index): counters advance, no vertex.
// Tile: the bit-serial divider forms 15 quotient bits, one a cycle, then the
// shared multiplier and clamp run through MUL_U, MUL_V and SAT_V, then six
// vertices are emitted. A vertex held off stalls the emit state until taken.
// Reset clears the counters and loads the register defaults; tiles.ready is low
// from acceptance of a non-empty tile until its sixth vertex transaction.
`timescale 1ns / 1ps

module tile_quad_vertex_generator_core #(
    parameter int MAX_MAP_DIM       = 1024,
    parameter int MAX_ATLAS_COLUMNS = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [tqvg_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [tqvg_pkg::CFG_DATA_W-1:0]   wr_data,
    tqvg_tile_if.sink                         tiles,
    tqvg_vertex_if.source                     vertices
);
    import tqvg_pkg::*;

    localparam int CNT_W  = $clog2(MAX_MAP_DIM);
    localparam int CNT1_W = CNT_W + 1;
    localparam int DIM_W  = $clog2(MAX_MAP_DIM + 1);
    localparam int COLS_W = $clog2(MAX_ATLAS_COLUMNS + 1);

    localparam logic [5:0] CORNER_DX = 6'b101010;
    localparam logic [5:0] CORNER_DY = 6'b110100;

    // Configuration
    logic [MAP_REG_W-1:0]   map_width_reg;
    logic [MAP_REG_W-1:0]   map_height_reg;
    logic [ATLAS_REG_W-1:0] atlas_cols_reg;
    logic [STEP_W-1:0]      step_x_reg;
    logic [STEP_W-1:0]      step_y_reg;
    logic [PAD_W-1:0]       pad_x_reg;
    logic [PAD_W-1:0]       pad_y_reg;

    // Control
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    col_reg, col_next;
    logic [CNT_W-1:0]    row_reg, row_next;
    logic [CORNER_W-1:0] corner_reg, corner_next;

    // Payload
    logic [CNT_W-1:0]    x_reg;
    logic [CNT_W-1:0]    y_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [TEX_W-1:0]    tu0_reg, tu1_reg;
    logic [TEX_W-1:0]    tv0_reg, tv1_reg;

    logic [DIM_W-1:0]    map_w;
    logic [DIM_W-1:0]    map_h;
    logic [COLS_W-1:0]   cols;
    logic [CNT1_W-1:0]   col_inc;
    logic [CNT1_W-1:0]   row_inc;
    logic                in_acc;
    logic                out_acc;
    logic                is_empty;
    logic                div_start;
    logic                div_done;
    logic [QUO_W-1:0]    div_quo;
    logic [COLS_W-1:0]   div_rem;
    logic [QUO_W-1:0]    mul_a;
    logic [STEP_W-1:0]   mul_b;
    logic [PROD_W-1:0]   mul_prod;
    logic [STEP_W-1:0]   add_step;
    logic [PAD_W-1:0]    add_pad;
    logic signed [SUM_W-1:0] near_sum;
    logic signed [SUM_W-1:0] far_sum;

    assign in_acc   = tiles.valid && tiles.ready;
    assign out_acc  = vertices.valid && vertices.ready;
    assign is_empty = tiles.tile_index[TILE_W-1];

    // Size registers: zero reads as one, oversize reads as the maximum
    always_comb
    begin
        if (map_width_reg == '0)
            map_w = DIM_W'(1);
        else if (32'(map_width_reg) > MAX_MAP_DIM)
            map_w = DIM_W'(MAX_MAP_DIM);
        else
            map_w = DIM_W'(map_width_reg);

        if (map_height_reg == '0)
            map_h = DIM_W'(1);
        else if (32'(map_height_reg) > MAX_MAP_DIM)
            map_h = DIM_W'(MAX_MAP_DIM);
        else
            map_h = DIM_W'(map_height_reg);

        if (atlas_cols_reg == '0)
            cols = COLS_W'(1);
        else if (32'(atlas_cols_reg) > MAX_ATLAS_COLUMNS)
            cols = COLS_W'(MAX_ATLAS_COLUMNS);
        else
            cols = COLS_W'(atlas_cols_reg);
    end

    // Cell counters; a counter past a shrunk map wraps on its next advance
    always_comb
    begin
        col_inc  = {1'b0, col_reg} + 1'b1;
        row_inc  = {1'b0, row_reg} + 1'b1;
        col_next = col_reg;
        row_next = row_reg;
        if (in_acc)
        begin
            if (col_inc >= CNT1_W'(map_w))
            begin
                col_next = '0;
                if (row_inc >= CNT1_W'(map_h))
                    row_next = '0;
                else
                    row_next = row_inc[CNT_W-1:0];
            end
            else
            begin
                col_next = col_inc[CNT_W-1:0];
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        corner_next = corner_reg;
        div_start   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && !is_empty)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_MUL_U;
            end
            ST_MUL_U:
                state_next = ST_MUL_V;
            ST_MUL_V:
                state_next = ST_SAT_V;
            ST_SAT_V:
            begin
                corner_next = '0;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_acc)
                begin
                    corner_next = corner_reg + 1'b1;
                    if (corner_reg == LAST_CORNER)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            col_reg        <= '0;
            row_reg        <= '0;
            corner_reg     <= '0;
            map_width_reg  <= MAP_REG_W'(1);
            map_height_reg <= MAP_REG_W'(1);
            atlas_cols_reg <= ATLAS_REG_W'(1);
            step_x_reg     <= STEP_RESET;
            step_y_reg     <= STEP_RESET;
            pad_x_reg      <= '0;
            pad_y_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            corner_reg <= corner_next;
            if (wr_en)
            begin
                unique case (cfg_idx_t'(wr_index))
                    CFG_MAP_WIDTH:     map_width_reg  <= wr_data[MAP_REG_W-1:0];
                    CFG_MAP_HEIGHT:    map_height_reg <= wr_data[MAP_REG_W-1:0];
                    CFG_ATLAS_COLUMNS: atlas_cols_reg <= wr_data[ATLAS_REG_W-1:0];
                    CFG_UV_STEP_X:     step_x_reg     <= wr_data[STEP_W-1:0];
                    CFG_UV_STEP_Y:     step_y_reg     <= wr_data[STEP_W-1:0];
                    CFG_PAD_X:         pad_x_reg      <= wr_data[PAD_W-1:0];
                    CFG_PAD_Y:         pad_y_reg      <= wr_data[PAD_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    tqvg_div #(
        .DIVISOR_W (COLS_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (tiles.tile_index[QUO_W-1:0]),
        .divisor   (cols),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Shared multiplier: atlas column by x step, then atlas row by y step
    assign mul_a    = (state_reg == ST_MUL_V) ? div_quo : QUO_W'(div_rem);
    assign mul_b    = (state_reg == ST_MUL_V) ? step_y_reg : step_x_reg;
    assign mul_prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Shared inset adder: x terms while the y product forms, y terms after
    assign add_step = (state_reg == ST_SAT_V) ? step_y_reg : step_x_reg;
    assign add_pad  = (state_reg == ST_SAT_V) ? pad_y_reg : pad_x_reg;
    assign near_sum = $signed(SUM_W'(prod_reg)) + $signed(SUM_W'(add_pad));
    assign far_sum  = near_sum + $signed(SUM_W'(add_step))
                    - $signed(SUM_W'({add_pad, 1'b0}));

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            x_reg <= col_reg;
            y_reg <= row_reg;
        end
        if (state_reg == ST_MUL_U || state_reg == ST_MUL_V)
            prod_reg <= mul_prod;
        if (state_reg == ST_MUL_V)
        begin
            tu0_reg <= sat_tex(near_sum);
            tu1_reg <= sat_tex(far_sum);
        end
        if (state_reg == ST_SAT_V)
        begin
            tv0_reg <= sat_tex(near_sum);
            tv1_reg <= sat_tex(far_sum);
        end
    end

    assign tiles.ready           = (state_reg == ST_IDLE);
    assign vertices.valid        = (state_reg == ST_EMIT);
    assign vertices.pos_x        = POS_W'(CNT1_W'(x_reg) + CNT1_W'(CORNER_DX[corner_reg]));
    assign vertices.pos_y        = POS_W'(CNT1_W'(y_reg) + CNT1_W'(CORNER_DY[corner_reg]));
    assign vertices.tex_u        = CORNER_DX[corner_reg] ? tu1_reg : tu0_reg;
    assign vertices.tex_v        = CORNER_DY[corner_reg] ? tv1_reg : tv0_reg;
    assign vertices.corner       = corner_reg;
    assign vertices.last_of_quad = (corner_reg == LAST_CORNER);

endmodule

FILE: hdl/tqvg_checker.sv
`timescale 1ns / 1ps

module tqvg_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic signed [tqvg_pkg::TILE_W-1:0]   in_tile_index,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic [tqvg_pkg::POS_W-1:0]           out_pos_x,
    input logic [tqvg_pkg::POS_W-1:0]           out_pos_y,
    input logic [tqvg_pkg::TEX_W-1:0]           out_tex_u,
    input logic [tqvg_pkg::TEX_W-1:0]           out_tex_v,
    input logic [tqvg_pkg::CORNER_W-1:0]        out_corner,
    input logic                                 out_last
);
    import tqvg_pkg::*;

    // Held vertex must not change under back-pressure
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_pos_x) && $stable(out_pos_y)
            && $stable(out_tex_u) && $stable(out_tex_v) && $stable(out_corner))
        else $error("vertex changed while stalled");

    // No new tile is taken while vertices of the previous one are pending
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("tile input open during vertex output");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_last == (out_corner == LAST_CORNER)))
        else $error("last_of_quad does not match corner");

    // Corners of one quad follow each other without gaps
    a_corner_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=>
            out_valid && (out_corner == CORNER_W'($past(out_corner) + 1'b1)))
        else $error("corner sequence broken");

    // Empty cell produces nothing and leaves the input open
    a_empty_cell: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_tile_index[TILE_W-1] |=> in_ready && !out_valid)
        else $error("empty cell started a quad");

endmodule

bind tile_quad_vertex_generator_core tqvg_checker u_tqvg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (tiles.valid),
    .in_ready      (tiles.ready),
    .in_tile_index (tiles.tile_index),
    .out_valid     (vertices.valid),
    .out_ready     (vertices.ready),
    .out_pos_x     (vertices.pos_x),
    .out_pos_y     (vertices.pos_y),
    .out_tex_u     (vertices.tex_u),
    .out_tex_v     (vertices.tex_v),
    .out_corner    (vertices.corner),
    .out_last      (vertices.last_of_quad)
);

FILE: sim/tile_quad_vertex_generator_core_tb.sv
`timescale 1ns / 1ps

module tile_quad_vertex_generator_core_tb;
    import tqvg_pkg::*;

    localparam int MAP_DIM_MAX    = 1024;
    localparam int ATLAS_COLS_MAX = 256;
    localparam int CELL_W         = 10;
    localparam int DRAIN_CYCLES   = 40;
    localparam int LONG_HOLD      = 300;
    localparam int QUIET_LIMIT    = 3000;
    localparam int RAND_SEGMENTS  = 8;
    localparam int SEG_TILES      = 45;
    localparam int MAX_REPORTS    = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
    // corners 2, 4 and 5 sit on the lower edge of the quad
    localparam logic [5:0] LOWER_EDGE = 6'b110100;

    typedef struct packed {
        logic [POS_W-1:0]    px;
        logic [POS_W-1:0]    py;
        logic [TEX_W-1:0]    u;
        logic [TEX_W-1:0]    v;
        logic [CORNER_W-1:0] corner;
        logic                last;
    } vertex_t;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [TILE_W-1:0]     tile;
        logic                  typed;
        logic [TEX_W-1:0]      u0;
        logic [TEX_W-1:0]      u1;
        logic [TEX_W-1:0]      v0;
        logic [TEX_W-1:0]      v1;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    tqvg_tile_if   tile_ch ();
    tqvg_vertex_if vert_ch ();

    tile_quad_vertex_generator_core #(
        .MAX_MAP_DIM       (MAP_DIM_MAX),
        .MAX_ATLAS_COLUMNS (ATLAS_COLS_MAX)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .tiles    (tile_ch),
        .vertices (vert_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // shadow registers and cell counters
    logic [MAP_REG_W-1:0]   cfg_map_w  = MAP_REG_W'(1);
    logic [MAP_REG_W-1:0]   cfg_map_h  = MAP_REG_W'(1);
    logic [ATLAS_REG_W-1:0] cfg_cols   = ATLAS_REG_W'(1);
    logic [STEP_W-1:0]      cfg_step_x = STEP_RESET;
    logic [STEP_W-1:0]      cfg_step_y = STEP_RESET;
    logic [PAD_W-1:0]       cfg_pad_x  = '0;
    logic [PAD_W-1:0]       cfg_pad_y  = '0;
    logic [CELL_W-1:0]      cell_col   = '0;
    logic [CELL_W-1:0]      cell_row   = '0;

    vertex_t pending_vertices [$];

    int tx_gap_pct   = 10;
    int rx_stall_pct = 59;
    int hold_req     = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    int mismatches   = 0;

    function automatic int eff_size(input int v, input int lim);
        if (v == 0)
            return 1;
        if (v > lim)
            return lim;
        return v;
    endfunction

    function automatic logic [TEX_W-1:0] clamp_tex(input longint v);
        if (v < 0)
            return '0;
        if (v > TEX_ONE)
            return TEX_W'(TEX_ONE);
        return TEX_W'(v);
    endfunction

    function automatic void build_quad(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                       input logic [TEX_W-1:0] u0, input logic [TEX_W-1:0] u1,
                                       input logic [TEX_W-1:0] v0, input logic [TEX_W-1:0] v1,
                                       output vertex_t q [6]);
        for (int k = 0; k < 6; k++)
        begin
            q[k].px     = x + POS_W'(k % 2);
            q[k].py     = y + POS_W'(LOWER_EDGE[k]);
            q[k].u      = (k % 2) ? u1 : u0;
            q[k].v      = LOWER_EDGE[k] ? v1 : v0;
            q[k].corner = CORNER_W'(k);
            q[k].last   = (CORNER_W'(k) == LAST_CORNER);
        end
    endfunction

    // Advances the cell counters; returns 1 with the quad for a non-empty cell.
    function automatic bit quad_for_tile(input logic signed [TILE_W-1:0] t,
                                         output vertex_t q [6]);
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] nxt;
        int               cols;
        longint           ac;
        longint           ar;
        longint           u0;
        longint           v0;
        longint           u1;
        longint           v1;
        x   = POS_W'(cell_col);
        y   = POS_W'(cell_row);
        nxt = x + 1'b1;
        // a counter past a shrunk map is still used here, then wraps
        if (nxt >= eff_size(cfg_map_w, MAP_DIM_MAX))
        begin
            cell_col = '0;
            nxt      = y + 1'b1;
            cell_row = (nxt >= eff_size(cfg_map_h, MAP_DIM_MAX)) ? '0 : nxt[CELL_W-1:0];
        end
        else
        begin
            cell_col = nxt[CELL_W-1:0];
        end
        if (t[TILE_W-1])
            return 1'b0;
        cols = eff_size(cfg_cols, ATLAS_COLS_MAX);
        ac   = longint'(t) % cols;
        ar   = longint'(t) / cols;
        u0   = ac * longint'(cfg_step_x) + longint'(cfg_pad_x);
        v0   = ar * longint'(cfg_step_y) + longint'(cfg_pad_y);
        u1   = u0 + longint'(cfg_step_x) - 2 * longint'(cfg_pad_x);
        v1   = v0 + longint'(cfg_step_y) - 2 * longint'(cfg_pad_y);
        build_quad(x, y, clamp_tex(u0), clamp_tex(u1), clamp_tex(v0), clamp_tex(v1), q);
        return 1'b1;
    endfunction

    function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input int data);
        dir_row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = CFG_DATA_W'(data);
        return r;
    endfunction

    function automatic dir_row_t tile_row(input int t);
        dir_row_t r;
        r      = '0;
        r.tile = TILE_W'(t);
        return r;
    endfunction

    // typed rows only run on a one-by-one map, so the cell is always at the origin
    function automatic dir_row_t typed_row(input int t, input int u0, input int u1,
                                           input int v0, input int v1);
        dir_row_t r;
        r       = tile_row(t);
        r.typed = 1'b1;
        r.u0    = TEX_W'(u0);
        r.u1    = TEX_W'(u1);
        r.v0    = TEX_W'(v0);
        r.v1    = TEX_W'(v1);
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        case (idx)
            CFG_MAP_WIDTH:     cfg_map_w  = data[MAP_REG_W-1:0];
            CFG_MAP_HEIGHT:    cfg_map_h  = data[MAP_REG_W-1:0];
            CFG_ATLAS_COLUMNS: cfg_cols   = data[ATLAS_REG_W-1:0];
            CFG_UV_STEP_X:     cfg_step_x = data[STEP_W-1:0];
            CFG_UV_STEP_Y:     cfg_step_y = data[STEP_W-1:0];
            CFG_PAD_X:         cfg_pad_x  = data[PAD_W-1:0];
            CFG_PAD_Y:         cfg_pad_y  = data[PAD_W-1:0];
            default:           ;
        endcase
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic send_tile(input logic signed [TILE_W-1:0] t, input bit typed,
                             input logic [TEX_W-1:0] u0, input logic [TEX_W-1:0] u1,
                             input logic [TEX_W-1:0] v0, input logic [TEX_W-1:0] v1);
        vertex_t quad [6];
        @(negedge clk);
        while ($urandom_range(99) < tx_gap_pct)
        begin
            tile_ch.valid      <= 1'b0;
            tile_ch.tile_index <= TILE_W'($urandom);
            @(negedge clk);
        end
        tile_ch.valid      <= 1'b1;
        tile_ch.tile_index <= t;
        @(posedge clk);
        while (!tile_ch.ready)
            @(posedge clk);
        if (quad_for_tile(t, quad))
        begin
            if (typed)
                build_quad('0, '0, u0, u1, v0, v1, quad);
            foreach (quad[k])
                pending_vertices.push_back(quad[k]);
        end
    endtask

    // Stop offering, let every vertex out, then give the block time to settle.
    task automatic wait_idle();
        @(negedge clk);
        tile_ch.valid <= 1'b0;
        while (pending_vertices.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // receiver: random stalls, plus one long hold-off counted here
    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            vert_ch.ready <= 1'b0;
        end
        else
        begin
            vert_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        vertex_t want;
        if (rst_n && vert_ch.valid && vert_ch.ready)
        begin
            if (pending_vertices.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: vertex with none expected: pos %0d,%0d corner %0d", $time,
                             vert_ch.pos_x, vert_ch.pos_y, vert_ch.corner);
            end
            else
            begin
                want = pending_vertices.pop_front();
                check_field("pos_x", want.px, vert_ch.pos_x);
                check_field("pos_y", want.py, vert_ch.pos_y);
                check_field("tex_u", want.u, vert_ch.tex_u);
                check_field("tex_v", want.v, vert_ch.tex_v);
                check_field("corner", want.corner, vert_ch.corner);
                check_field("last_of_quad", want.last, vert_ch.last_of_quad);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((tile_ch.valid && tile_ch.ready) || (vert_ch.valid && vert_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("no transaction for %0d cycles", QUIET_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        dir_row_t          dir_rows [$];
        dir_row_t          row;
        bit                busy;
        cfg_idx_t          regs [7];
        int                widths [7];
        int                vals [7];
        int                small_tiles [8];
        int                r;
        int                cols_eff;
        logic [CFG_DATA_W-1:0] data;
        logic [TILE_W-1:0] t;

        rst_n              = 1'b0;
        wr_en              = 1'b0;
        wr_index           = '0;
        wr_data            = '0;
        tile_ch.valid      = 1'b0;
        tile_ch.tile_index = '0;
        vert_ch.ready      = 1'b0;

        regs   = '{CFG_MAP_WIDTH, CFG_MAP_HEIGHT, CFG_ATLAS_COLUMNS, CFG_UV_STEP_X,
                   CFG_UV_STEP_Y, CFG_PAD_X, CFG_PAD_Y};
        widths = '{MAP_REG_W, MAP_REG_W, ATLAS_REG_W, STEP_W, STEP_W, PAD_W, PAD_W};
        small_tiles = '{0, 1, 2, 3, 4, 5, 7, -2};

        // defaults after reset
        dir_rows.push_back(typed_row(0, 0, TEX_ONE, 0, TEX_ONE));
        dir_rows.push_back(tile_row(-1));
        dir_rows.push_back(tile_row(-32768));
        dir_rows.push_back(typed_row(32767, 0, TEX_ONE, TEX_ONE, TEX_ONE));
        dir_rows.push_back(tile_row('h5555));
        // write to a register that does not exist
        dir_rows.push_back(cfg_row(CFG_IDX_UNUSED, 'h1FFFF));
        dir_rows.push_back(typed_row(0, 0, TEX_ONE, 0, TEX_ONE));
        // small map, counters wrap both ways
        dir_rows.push_back(cfg_row(CFG_MAP_WIDTH, 3));
        dir_rows.push_back(cfg_row(CFG_MAP_HEIGHT, 2));
        dir_rows.push_back(cfg_row(CFG_ATLAS_COLUMNS, 4));
        dir_rows.push_back(cfg_row(CFG_UV_STEP_X, 16384));
        dir_rows.push_back(cfg_row(CFG_UV_STEP_Y, 32768));
        dir_rows.push_back(cfg_row(CFG_PAD_X, 1024));
        dir_rows.push_back(cfg_row(CFG_PAD_Y, 2048));
        foreach (small_tiles[i])
            dir_rows.push_back(tile_row(small_tiles[i]));
        // zero sizes, inset beyond step, map shrunk under the counters
        dir_rows.push_back(cfg_row(CFG_MAP_WIDTH, 0));
        dir_rows.push_back(cfg_row(CFG_MAP_HEIGHT, 0));
        dir_rows.push_back(cfg_row(CFG_ATLAS_COLUMNS, 0));
        dir_rows.push_back(cfg_row(CFG_UV_STEP_X, 65536));
        dir_rows.push_back(cfg_row(CFG_UV_STEP_Y, 0));
        dir_rows.push_back(cfg_row(CFG_PAD_X, 32768));
        dir_rows.push_back(cfg_row(CFG_PAD_Y, 32768));
        dir_rows.push_back(tile_row(0));
        dir_rows.push_back(tile_row(3));
        // oversize registers, coordinates above one
        dir_rows.push_back(cfg_row(CFG_MAP_WIDTH, 2047));
        dir_rows.push_back(cfg_row(CFG_MAP_HEIGHT, 'h1FFFF));
        dir_rows.push_back(cfg_row(CFG_ATLAS_COLUMNS, 511));
        dir_rows.push_back(cfg_row(CFG_UV_STEP_X, 65535));
        dir_rows.push_back(cfg_row(CFG_UV_STEP_Y, 'h1FFFF));
        dir_rows.push_back(cfg_row(CFG_PAD_X, 'hFFFF));
        dir_rows.push_back(cfg_row(CFG_PAD_Y, 1));
        dir_rows.push_back(tile_row(255));
        dir_rows.push_back(tile_row(256));
        dir_rows.push_back(tile_row(32767));
        dir_rows.push_back(tile_row(1000));
        dir_rows.push_back(cfg_row(CFG_MAP_WIDTH, 2));
        dir_rows.push_back(cfg_row(CFG_MAP_HEIGHT, 2));
        dir_rows.push_back(tile_row(6));
        dir_rows.push_back(tile_row(-5));
        dir_rows.push_back(tile_row(9));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        busy = 1'b0;
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.is_cfg)
            begin
                if (busy)
                    wait_idle();
                busy = 1'b0;
                write_reg(row.idx, row.data);
            end
            else
            begin
                send_tile(row.tile, row.typed, row.u0, row.u1, row.v0, row.v1);
                busy = 1'b1;
            end
        end

        for (int seg = 0; seg < RAND_SEGMENTS; seg++)
        begin
            wait_idle();
            tx_gap_pct   = (seg < 3) ? 10 : (seg < 6) ? 59 : 0;
            rx_stall_pct = (seg < 3) ? 59 : (seg < 6) ? 10 : 0;
            case (seg)
                0:       vals = '{MAP_DIM_MAX, MAP_DIM_MAX, ATLAS_COLS_MAX, TEX_ONE, TEX_ONE,
                                  TEX_ONE / 2, TEX_ONE / 2};
                1:       vals = '{1, 1, 1, 0, 0, 0, 0};
                default:
                begin
                    for (int k = 0; k < 2; k++)
                    begin
                        r = $urandom_range(9);
                        vals[k] = (r < 7) ? $urandom_range(1, 6) :
                                  (r < 9) ? $urandom_range(0, 2047) : 0;
                    end
                    r = $urandom_range(9);
                    vals[2] = (r < 6) ? $urandom_range(1, 16) :
                              (r < 9) ? $urandom_range(17, 511) : 0;
                    cols_eff = eff_size(vals[2], ATLAS_COLS_MAX);
                    r = $urandom_range(9);
                    vals[3] = (r < 5) ? TEX_ONE / cols_eff :
                              (r < 8) ? $urandom_range(0, TEX_ONE) : $urandom_range(0, 131071);
                    r = $urandom_range(9);
                    vals[4] = (r < 5) ? TEX_ONE / $urandom_range(1, 64) :
                              (r < 8) ? $urandom_range(0, TEX_ONE) : $urandom_range(0, 131071);
                    for (int k = 5; k < 7; k++)
                    begin
                        r = $urandom_range(9);
                        vals[k] = (r < 6) ? $urandom_range(0, vals[k - 2] >> 3) :
                                  (r < 9) ? $urandom_range(0, TEX_ONE / 2) :
                                  $urandom_range(0, 65535);
                    end
                end
            endcase
            foreach (regs[k])
            begin
                data = CFG_DATA_W'(vals[k]);
                // junk above the register width now and then
                if ($urandom_range(7) == 0)
                    data = data | CFG_DATA_W'($urandom << widths[k]);
                write_reg(regs[k], data);
            end
            if (seg == 6)
                hold_req++;
            cols_eff = eff_size(cfg_cols, ATLAS_COLS_MAX);
            repeat (SEG_TILES)
            begin
                r = $urandom_range(99);
                if (r < 20)
                    t = {1'b1, 15'($urandom)};
                else if (r < 35)
                    t = {1'b0, 15'($urandom)};
                else
                    t = TILE_W'($urandom_range(0, 4 * cols_eff + 3));
                send_tile(t, 1'b0, '0, '0, '0, '0);
            end
        end

        wait_idle();
        if (mismatches == 0 && pending_vertices.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
